/* rtl/core/wdd_pkg.sv */
// Shared constants and types for the windowed duplicate detector.
package wdd_pkg;

  localparam int MaxDist   = 16;
  localparam int IndexBits = 16;
  localparam int ValueW    = 32;
  localparam int OutIdxW   = 16;
  localparam int CfgW      = 5;
  localparam int DistW     = $clog2(MaxDist + 1);
  localparam int CmpW      = (DistW > CfgW) ? DistW : CfgW;

  localparam logic [CfgW-1:0] CfgReset = CfgW'(2);

  typedef logic [IndexBits-1:0] pos_t;

  // One window slot: stored value and its valid bit.
  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
  } cell_t;

  typedef enum logic [1:0] {
    StNone = 2'd0,
    StPair = 2'd1,
    StDone = 2'd2
  } status_e;

endpackage

/* rtl/core/wdd_cell.sv */
// One window slot: holds a value, shifts it onward, compares it with the new beat.
module wdd_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic                  clear_i,
  input  wdd_pkg::cell_t        prev_i,
  input  logic [wdd_pkg::ValueW-1:0] cmp_value_i,
  output wdd_pkg::cell_t        cell_o,
  output logic                  hit_o
);
  import wdd_pkg::*;

  logic              valid_q, valid_d;
  logic [ValueW-1:0] value_q, value_d;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (shift_i) begin
      valid_d = prev_i.valid;
      value_d = prev_i.value;
    end
    // end of sequence wins over the shift
    if (clear_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o = '{valid: valid_q, value: value_q};
  assign hit_o  = valid_q && (value_q == cmp_value_i);

endmodule

/* rtl/core/windowed_duplicate_detector.sv */
// Top level: detects the first pair of equal values within max_distance positions.
// Output: a result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the result stream is ready; all sixteen window cells compare in parallel and
//   the nearest hit is picked in the same cycle, feeding a single output register.
// Reset: clears the window valid bits, position, found flag and output valid;
//   max_distance returns to 2. No clearing pass is needed after reset.
module windowed_duplicate_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: max_distance
  input  logic        cfg_we_i,
  input  logic [wdd_pkg::CfgW-1:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic        s_axis_tlast_i,   // last
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] later_index, [31:16] earlier_index
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  output logic        m_axis_tlast_o    // end_of_sequence
);
  import wdd_pkg::*;

  // ---------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------
  logic [CfgW-1:0] max_dist_q;
  logic [CmpW-1:0] limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= CfgReset;
    end else if (cfg_we_i) begin
      max_dist_q <= cfg_wdata_i;
    end
  end

  // a distance beyond the window acts as the full window
  assign limit = (CmpW'(max_dist_q) > CmpW'(MaxDist)) ? CmpW'(MaxDist) : CmpW'(max_dist_q);

  // ---------------------------------------------------------------
  // Handshake: output register decouples the two sides
  // ---------------------------------------------------------------
  logic out_valid_q;
  logic s_fire;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------
  // Window: chain of cells, cell i holds the value at distance i+1
  // ---------------------------------------------------------------
  cell_t             chain [MaxDist+1];
  logic [MaxDist-1:0] hit;
  logic [MaxDist-1:0] hit_m;
  logic [ValueW-1:0] in_value;

  assign in_value = s_axis_tdata_i[ValueW-1:0];
  assign chain[0] = '{valid: 1'b1, value: in_value};

  for (genvar i = 0; i < MaxDist; i++) begin : g_cell
    wdd_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (s_fire),
      .clear_i     (s_fire && s_axis_tlast_i),
      .prev_i      (chain[i]),
      .cmp_value_i (in_value),
      .cell_o      (chain[i+1]),
      .hit_o       (hit[i])
    );
    // only gaps up to the configured distance count
    assign hit_m[i] = hit[i] && (CmpW'(i + 1) <= limit);
  end

  // nearest hit wins: scan from far to near so the lowest index sticks
  logic             found;
  logic [DistW-1:0] gap;

  always_comb begin
    found = 1'b0;
    gap   = '0;
    for (int i = MaxDist - 1; i >= 0; i--) begin
      if (hit_m[i]) begin
        found = 1'b1;
        gap   = DistW'(i + 1);
      end
    end
  end

  // ---------------------------------------------------------------
  // Sequence state: position counter and found flag
  // ---------------------------------------------------------------
  pos_t pos_q, pos_d;
  logic pair_q, pair_d;
  pos_t earlier;
  logic new_pair;

  assign new_pair = found && !pair_q;
  assign earlier  = (pos_q >= pos_t'(gap)) ? pos_q - pos_t'(gap) : '0;

  always_comb begin
    pos_d  = pos_q;
    pair_d = pair_q;
    if (s_fire) begin
      if (pos_q != '1) begin
        pos_d = pos_q + pos_t'(1);   // saturates at all ones
      end
      if (new_pair) begin
        pair_d = 1'b1;
      end
      if (s_axis_tlast_i) begin
        pos_d  = '0;
        pair_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pair_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      pair_q <= pair_d;
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  status_e             status_q, status_d;
  logic [OutIdxW-1:0]  later_q, later_d;
  logic [OutIdxW-1:0]  earlier_q, earlier_d;
  logic                eos_q;

  always_comb begin
    status_d  = StNone;
    later_d   = '0;
    earlier_d = '0;
    if (pair_q) begin
      status_d = StDone;
    end else if (found) begin
      status_d  = StPair;
      later_d   = OutIdxW'(pos_q);
      earlier_d = OutIdxW'(earlier);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      status_q  <= status_d;
      later_q   <= later_d;
      earlier_q <= earlier_d;
      eos_q     <= s_axis_tlast_i;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {earlier_q, later_q};
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tlast_o  = eos_q;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast_i |=> (pos_q == '0) && !pair_q)
    else $error("sequence state not cleared after last beat");

  a_rise_reports_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pair_q) |-> out_valid_q && (status_q == StPair))
    else $error("found flag set without a pair result");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == StPair) |-> earlier_q < later_q)
    else $error("earlier index not below later index");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !s_axis_tlast_i |=> chain[1].valid)
    else $error("newest window cell not valid after a beat");

  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (limit == '0) |-> !new_pair)
    else $error("pair reported with matching disabled");

endmodule
